/* rtl/core/lapic_pkg.sv */
// ----------------------------------------------------------------------------
// Local APIC timer package
// Shared types, register offsets and the divide table for the timer core.
// ----------------------------------------------------------------------------
package lapic_pkg;

    // Default counter width, handed to the top-level parameter.
    localparam int COUNTER_WIDTH_DEF = 32;

    // Transaction kinds carried on the opcode field.
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    // Register offsets, expressed as byte offset divided by four.
    localparam logic [7:0] OFF_EOI = 8'h2c;
    localparam logic [7:0] OFF_SVR = 8'h3c;
    localparam logic [7:0] OFF_LVT = 8'hc8;
    localparam logic [7:0] OFF_ICR = 8'he0;
    localparam logic [7:0] OFF_CCR = 8'he4;
    localparam logic [7:0] OFF_DCR = 8'hf8;

    // Bits kept on a write to the divide register (bits 3, 1 and 0).
    localparam logic [3:0] DCR_KEEP = 4'hb;

    // Divisor selected by {divide[3], divide[1:0]}.
    localparam logic [7:0] DIV_TABLE [8] = '{
        8'd2, 8'd4, 8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'd1
    };

    // One result transaction.
    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_fire;
        logic [7:0]  irq_vector;
        logic        irq_pending;
    } result_t;

    // Occupancy of the output buffer, reported to the top level.
    typedef struct packed {
        logic main_full;
        logic skid_full;
    } buf_status_t;

endpackage

/* rtl/core/lapic_timer_regs.sv */
// ----------------------------------------------------------------------------
// Local APIC timer register file and counter
// Holds the timer state and forms the result of one transaction in one pass.
// ----------------------------------------------------------------------------
module lapic_timer_regs #(
    parameter int COUNTER_WIDTH = lapic_pkg::COUNTER_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  lapic_pkg::opcode_t opcode,
    input  logic [7:0]         reg_word,
    input  logic [31:0]        write_data,
    output lapic_pkg::result_t res
);
    import lapic_pkg::*;

    logic [8:0]               svr_reg, svr_next;
    logic [7:0]               lvt_vec_reg, lvt_vec_next;
    logic                     lvt_mask_reg, lvt_mask_next;
    logic                     lvt_periodic_reg, lvt_periodic_next;
    logic [3:0]               dcr_reg, dcr_next;
    logic [COUNTER_WIDTH-1:0] icr_reg, icr_next;
    logic [COUNTER_WIDTH-1:0] ccr_reg, ccr_next;
    logic [6:0]               presc_reg, presc_next;
    logic                     pending_reg, pending_next;

    logic [6:0]               presc_inc;
    logic [7:0]               div_value;
    logic                     tick_edge;
    logic [COUNTER_WIDTH-1:0] ccr_dec;

    assign presc_inc = presc_reg + 7'd1;
    assign div_value = DIV_TABLE[{dcr_reg[3], dcr_reg[1:0]}];
    assign tick_edge = ({1'b0, presc_inc} >= div_value) || (presc_inc == 7'd0);
    assign ccr_dec   = ccr_reg - COUNTER_WIDTH'(1);

    always_comb
    begin
        svr_next          = svr_reg;
        lvt_vec_next      = lvt_vec_reg;
        lvt_mask_next     = lvt_mask_reg;
        lvt_periodic_next = lvt_periodic_reg;
        dcr_next          = dcr_reg;
        icr_next          = icr_reg;
        ccr_next          = ccr_reg;
        presc_next        = presc_reg;
        pending_next      = pending_reg;
        res               = '0;

        unique case (opcode)
            OP_READ:
            begin
                unique case (reg_word)
                    OFF_SVR: res.read_data = 32'(svr_reg);
                    OFF_LVT: res.read_data = {14'd0, lvt_periodic_reg, lvt_mask_reg,
                                              8'd0, lvt_vec_reg};
                    OFF_ICR: res.read_data = 32'(icr_reg);
                    OFF_CCR: res.read_data = 32'(ccr_reg);
                    OFF_DCR: res.read_data = 32'(dcr_reg);
                    default: res.read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                unique case (reg_word)
                    OFF_EOI: pending_next = 1'b0;
                    OFF_SVR: svr_next = write_data[8:0];
                    OFF_LVT:
                    begin
                        lvt_vec_next      = write_data[7:0];
                        lvt_mask_next     = write_data[16];
                        lvt_periodic_next = write_data[17];
                    end
                    OFF_ICR:
                    begin
                        icr_next   = write_data[COUNTER_WIDTH-1:0];
                        ccr_next   = write_data[COUNTER_WIDTH-1:0];
                        presc_next = '0;
                    end
                    OFF_DCR: dcr_next = write_data[3:0] & DCR_KEEP;
                    default: ;
                endcase
            end
            OP_TICK:
            begin
                if (ccr_reg != '0)
                begin
                    presc_next = presc_inc;
                    if (tick_edge)
                    begin
                        presc_next = '0;
                        ccr_next   = ccr_dec;
                        if (ccr_dec == '0)
                        begin
                            if (svr_reg[8] && !lvt_mask_reg)
                            begin
                                res.irq_fire   = 1'b1;
                                res.irq_vector = lvt_vec_reg;
                                pending_next   = 1'b1;
                            end
                            if (lvt_periodic_reg)
                            begin
                                ccr_next = icr_reg;
                            end
                        end
                    end
                end
            end
            OP_NONE: ;
        endcase

        res.irq_pending = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            svr_reg          <= '0;
            lvt_vec_reg      <= '0;
            lvt_mask_reg     <= 1'b1;
            lvt_periodic_reg <= 1'b0;
            dcr_reg          <= '0;
            icr_reg          <= '0;
            ccr_reg          <= '0;
            presc_reg        <= '0;
            pending_reg      <= 1'b0;
        end
        else if (step_en)
        begin
            svr_reg          <= svr_next;
            lvt_vec_reg      <= lvt_vec_next;
            lvt_mask_reg     <= lvt_mask_next;
            lvt_periodic_reg <= lvt_periodic_next;
            dcr_reg          <= dcr_next;
            icr_reg          <= icr_next;
            ccr_reg          <= ccr_next;
            presc_reg        <= presc_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

/* rtl/core/lapic_out_buf.sv */
// ----------------------------------------------------------------------------
// Local APIC timer output buffer
// Result register with a skid entry so input and output stall independently.
// ----------------------------------------------------------------------------
module lapic_out_buf (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  lapic_pkg::result_t     push_data,
    output logic                   can_push,
    output logic                   out_valid,
    input  logic                   out_ready,
    output lapic_pkg::result_t     out_data,
    output lapic_pkg::buf_status_t status
);
    import lapic_pkg::*;

    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_push  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign status    = '{main_full: main_valid_reg, skid_full: skid_valid_reg};

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;

        if (pop && skid_valid_reg)
        begin
            // The skid entry moves up; no push is possible this cycle.
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        else if (pop)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push && !main_valid_reg)
        begin
            main_next       = push_data;
            main_valid_next = 1'b1;
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* rtl/core/local_apic_timer_core.sv */
// ----------------------------------------------------------------------------
// Local APIC timer core
// Register file and divided down-counter of a local interrupt controller timer.
// ----------------------------------------------------------------------------
// Each input transaction is a register read, a register write or one bus clock
// tick, chosen by opcode. Every input transaction yields exactly one output
// transaction carrying read_data, irq_fire, irq_vector and irq_pending.
// The input channel (in_valid/in_ready) and the output channel
// (out_valid/out_ready) are independent valid/ready handshakes.
// The result of an accepted transaction goes to the result register, or to
// the skid entry while the result register holds a result not taken then.
// Throughput is one transaction per cycle while in_ready is high. The
// register file updates at the accepting edge, so a tick may follow a write
// in the very next cycle. The result register is backed by a one-entry skid
// buffer; in_ready drops only when both hold results, that is after the
// receiver has stalled while a new transaction arrived.
// Reset clears all timer state (timer entry masked, counter stopped) and
// empties the output buffer; no clearing pass is needed.
// ----------------------------------------------------------------------------
module local_apic_timer_core #(
    parameter int COUNTER_WIDTH = lapic_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  reg_word,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        irq_fire,
    output logic [7:0]  irq_vector,
    output logic        irq_pending
);
    import lapic_pkg::*;

    logic        accept;
    result_t     step_res;
    result_t     out_res;
    buf_status_t buf_status;

    // A transaction is taken whenever the skid entry is free.
    assign accept = in_valid && in_ready;

    // Timer state and the single-pass result logic.
    lapic_timer_regs #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .opcode     (opcode_t'(opcode)),
        .reg_word   (reg_word),
        .write_data (write_data),
        .res        (step_res)
    );

    // Result register plus skid entry toward the receiver.
    lapic_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (step_res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_res),
        .status    (buf_status)
    );

    assign read_data   = out_res.read_data;
    assign irq_fire    = out_res.irq_fire;
    assign irq_vector  = out_res.irq_vector;
    assign irq_pending = out_res.irq_pending;

`ifndef SYNTHESIS
    // A firing tick always leaves the pending flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && irq_fire |-> irq_pending)
        else $error("irq_fire without irq_pending");

    // The vector is reported only together with a fire.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !irq_fire |-> irq_vector == 8'd0)
        else $error("irq_vector set without irq_fire");

    // The skid entry is only ever occupied behind a full result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        buf_status.skid_full |-> buf_status.main_full && out_valid)
        else $error("skid entry full while result register empty");

    // The skid entry fills only on a cycle where the receiver stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(buf_status.skid_full) |-> $past(out_valid && !out_ready && accept))
        else $error("skid entry filled without a stall");
`endif

endmodule

/* tb/local_apic_timer_checker.sv */
// ----------------------------------------------------------------------------
// Local APIC timer checker
// Watches both channels of the timer core, predicts every result and compares.
// ----------------------------------------------------------------------------
// Each accepted input transaction runs through a local copy of the timer
// (register file, prescaler, down-counter, pending flag). The predicted result
// is queued, and each accepted output transaction is compared field by field
// against the oldest queued result.
// ----------------------------------------------------------------------------
module local_apic_timer_checker #(
    parameter int COUNTER_WIDTH = lapic_pkg::COUNTER_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  reg_word,
    input  logic [31:0] write_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] read_data,
    input  logic        irq_fire,
    input  logic [7:0]  irq_vector,
    input  logic        irq_pending,
    output int unsigned failures,
    output int unsigned outstanding,
    output int unsigned fires
);
    import lapic_pkg::*;

    localparam logic [31:0] SVR_KEEP   = 32'h0000_01ff;
    localparam logic [31:0] LVT_KEEP   = 32'h0003_00ff;
    localparam logic [31:0] LVT_RESET  = 32'h0001_0000;
    localparam int          SVR_ENABLE = 8;
    localparam int          LVT_MASKED = 16;
    localparam int          LVT_PERIOD = 17;
    localparam logic [31:0] COUNT_MASK =
        (COUNTER_WIDTH >= 32) ? 32'hffff_ffff : ((32'd1 << COUNTER_WIDTH) - 32'd1);
    localparam int unsigned REPORT_LIMIT = 10;

    // Local copy of the timer state.
    logic [31:0] svr_q;
    logic [31:0] lvt_q;
    logic [3:0]  dcr_q;
    logic [31:0] icount_q;
    logic [31:0] ccount_q;
    logic [6:0]  presc_q;
    logic        irq_flag_q;

    result_t     results_due[$];
    int unsigned fail_count    = 0;
    int unsigned fire_count    = 0;
    int unsigned due_count     = 0;
    int unsigned results_seen  = 0;

    assign failures    = fail_count;
    assign outstanding = due_count;
    assign fires       = fire_count;

    // Applies one transaction to the local timer and returns its result.
    task automatic lapic_step(input opcode_t op, input logic [7:0] word,
                              input logic [31:0] data, output result_t res);
        logic [2:0] sel;
        logic [7:0] divisor;
        res = '0;
        case (op)
            OP_READ: begin
                case (word)
                    OFF_SVR: res.read_data = svr_q;
                    OFF_LVT: res.read_data = lvt_q;
                    OFF_ICR: res.read_data = icount_q;
                    OFF_CCR: res.read_data = ccount_q;
                    OFF_DCR: res.read_data = {28'd0, dcr_q};
                    default: res.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (word)
                    OFF_EOI: irq_flag_q = 1'b0;
                    OFF_SVR: svr_q = data & SVR_KEEP;
                    OFF_LVT: lvt_q = data & LVT_KEEP;
                    OFF_ICR: begin
                        icount_q = data & COUNT_MASK;
                        ccount_q = icount_q;
                        presc_q  = '0;
                    end
                    OFF_DCR: dcr_q = data[3:0] & DCR_KEEP;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (ccount_q != '0) begin
                    presc_q = presc_q + 7'd1;
                    sel     = {dcr_q[3], dcr_q[1:0]};
                    divisor = (sel == 3'd7) ? 8'd1 : (8'd2 << sel);
                    // A wrap of the prescaler also counts as a divided edge.
                    if ({1'b0, presc_q} >= divisor || presc_q == '0) begin
                        presc_q  = '0;
                        ccount_q = (ccount_q - 32'd1) & COUNT_MASK;
                        if (ccount_q == '0) begin
                            if (svr_q[SVR_ENABLE] && !lvt_q[LVT_MASKED]) begin
                                res.irq_fire   = 1'b1;
                                res.irq_vector = lvt_q[7:0];
                                irq_flag_q     = 1'b1;
                            end
                            if (lvt_q[LVT_PERIOD])
                                ccount_q = icount_q;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.irq_pending = irq_flag_q;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("Mismatch in result %0d, %s: expected %h, got %h",
                         results_seen, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t due;
        if (!rst_n) begin
            svr_q      = '0;
            lvt_q      = LVT_RESET;
            dcr_q      = '0;
            icount_q   = '0;
            ccount_q   = '0;
            presc_q    = '0;
            irq_flag_q = 1'b0;
            results_due.delete();
        end else begin
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Unexpected result %0d: read_data %h irq_fire %b",
                                 results_seen, read_data, irq_fire);
                end else begin
                    due = results_due.pop_front();
                    check_field("read_data",   due.read_data,   read_data);
                    check_field("irq_fire",    32'(due.irq_fire),    32'(irq_fire));
                    check_field("irq_vector",  32'(due.irq_vector),  32'(irq_vector));
                    check_field("irq_pending", 32'(due.irq_pending), 32'(irq_pending));
                    if (due.irq_fire)
                        fire_count++;
                end
                results_seen++;
            end
            if (in_valid && in_ready) begin
                lapic_step(opcode_t'(opcode), reg_word, write_data, due);
                results_due.push_back(due);
            end
        end
        due_count = results_due.size();
    end

endmodule

/* tb/local_apic_timer_core_test.sv */
// ----------------------------------------------------------------------------
// Local APIC timer core test
// Drives register and tick transactions into the timer core and gives a verdict.
// ----------------------------------------------------------------------------
// A short directed pass walks the reset values, reserved bits, masked and
// unmasked expiry, the pending flag, the unused opcode, a stop and a divide
// change in the middle of a count. The random pass then mostly programs the
// timer with random content and lets it run, with some noise in between.
// Prediction and comparison live in the checker beside the core.
// ----------------------------------------------------------------------------
module local_apic_timer_core_test;
    import lapic_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 7;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          QUIET_TAIL    = 80;
    localparam int          HOLD_CYCLES   = 40;
    localparam int          TAIL_CYCLES   = 5;
    localparam int unsigned CYCLE_LIMIT   = 200_000;

    localparam logic [7:0]  KNOWN_OFFSETS [6] = '{
        OFF_EOI, OFF_SVR, OFF_LVT, OFF_ICR, OFF_CCR, OFF_DCR
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    opcode_t     opcode;
    logic [7:0]  reg_word;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] read_data;
    logic        irq_fire;
    logic [7:0]  irq_vector;
    logic        irq_pending;

    int unsigned failures;
    int unsigned outstanding;
    int unsigned fires;

    // Knobs set by the stimulus for the sender and the receiver processes.
    bit          sender_idles;
    bit          receiver_stalls;
    bit          hold_request;

    int unsigned items_sent;
    int unsigned reads_sent;
    int unsigned writes_sent;
    int unsigned ticks_sent;
    int unsigned cycle_count;

    local_apic_timer_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .reg_word    (reg_word),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .irq_fire    (irq_fire),
        .irq_vector  (irq_vector),
        .irq_pending (irq_pending)
    );

    local_apic_timer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .reg_word    (reg_word),
        .write_data  (write_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .irq_fire    (irq_fire),
        .irq_vector  (irq_vector),
        .irq_pending (irq_pending),
        .failures    (failures),
        .outstanding (outstanding),
        .fires       (fires)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Offers one transaction and returns once the core has taken it.
    // Inputs only change at the falling edge, so the core always sees a
    // settled payload at the rising edge that accepts it. While idling, the
    // payload carries junk to show that an invalid cycle is ignored.
    task automatic offer(input opcode_t op, input logic [7:0] word,
                         input logic [31:0] data);
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            in_valid   = 1'b0;
            opcode     = opcode_t'($urandom_range(0, 3));
            reg_word   = 8'($urandom);
            write_data = $urandom;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        reg_word   = word;
        write_data = data;
        do
            @(posedge clk);
        while (!in_ready);
        case (op)
            OP_READ:  reads_sent++;
            OP_WRITE: writes_sent++;
            OP_TICK:  ticks_sent++;
            default:  ;
        endcase
        // The unused opcode changes nothing, so it does not count as work.
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Programs the timer with random content and then lets it run for a
    // burst of ticks. Most choices lean toward short counts and small
    // divisors so that expiry, reload and the pending flag come up often.
    task automatic run_timer_program();
        logic [31:0] data;
        logic [3:0]  div_bits;
        int          n_ticks;
        int          k;
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       div_bits = 4'hb;
                1:       div_bits = 4'h0;
                2:       div_bits = 4'h1;
                default: div_bits = 4'($urandom);
            endcase
            data = ($urandom & ~32'h0000_000b) | {28'd0, div_bits & DCR_KEEP};
            offer(OP_WRITE, OFF_DCR, data);
        end
        data = $urandom;
        if ($urandom_range(0, 4) != 0)
            data[16] = 1'b0;
        offer(OP_WRITE, OFF_LVT, data);
        data = $urandom;
        if ($urandom_range(0, 6) != 0)
            data[8] = 1'b1;
        offer(OP_WRITE, OFF_SVR, data);
        case ($urandom_range(0, 9))
            0:       data = '0;
            1:       data = $urandom;
            default: data = $urandom_range(1, 6);
        endcase
        offer(OP_WRITE, OFF_ICR, data);

        // A rare long burst lets the largest divisor wrap its prescaler.
        n_ticks = ($urandom_range(0, 11) == 0) ? $urandom_range(129, 160)
                                               : $urandom_range(4, 30);
        for (k = 0; k < n_ticks; k++)
        begin
            case ($urandom_range(0, 11))
                0:       offer(OP_READ, OFF_CCR, $urandom);
                1:       offer(OP_WRITE, OFF_EOI, $urandom);
                2:       offer(OP_READ, KNOWN_OFFSETS[$urandom_range(0, 5)], $urandom);
                3:
                begin
                    if ($urandom_range(0, 3) == 0)
                        offer(OP_WRITE, OFF_DCR, $urandom);
                    else
                        offer(OP_TICK, 8'($urandom), $urandom);
                end
                default: offer(OP_TICK, 8'($urandom), $urandom);
            endcase
        end
    endtask

    // A few transactions with any opcode, offset and data.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            if ($urandom_range(0, 1) == 0)
                offer(opcode_t'($urandom_range(0, 3)),
                      KNOWN_OFFSETS[$urandom_range(0, 5)], $urandom);
            else
                offer(opcode_t'($urandom_range(0, 3)), 8'($urandom), $urandom);
        end
    endtask

    // Receiver. It stalls in short random bursts while allowed, and once on
    // request it holds off for a long stretch so that the core fills up and
    // has to stall its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding",
                 cycle_count, outstanding);
        $display("FAIL local_apic_timer_core");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int unsigned random_end;
        bit          held_off;
        bit          paused;
        bit          quiet;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        opcode          = OP_READ;
        reg_word        = '0;
        write_data      = '0;
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 1'b0;
        items_sent      = 0;
        reads_sent      = 0;
        writes_sent     = 0;
        ticks_sent      = 0;
        held_off        = 1'b0;
        paused          = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed pass. The entry resets masked, so its value is read first.
        offer(OP_READ,  OFF_LVT, 32'h0);
        offer(OP_TICK,  8'h00,   32'hffff_ffff);    // stopped counter
        offer(OP_WRITE, OFF_CCR, 32'hffff_ffff);    // current count is read only
        offer(OP_WRITE, OFF_SVR, 32'hffff_ffff);    // reserved bits dropped
        offer(OP_READ,  OFF_SVR, 32'h0);
        offer(OP_WRITE, OFF_DCR, 32'hffff_ffff);    // divide by one
        offer(OP_READ,  OFF_DCR, 32'h0);
        offer(OP_WRITE, OFF_LVT, 32'hffff_ffff);    // masked, periodic, vector ff
        offer(OP_READ,  OFF_LVT, 32'h0);
        // Expiry while masked: no interrupt, but the periodic reload happens.
        offer(OP_WRITE, OFF_ICR, 32'd2);
        offer(OP_TICK,  8'hff,   32'h0);
        offer(OP_TICK,  8'hff,   32'h0);
        offer(OP_READ,  OFF_CCR, 32'h0);
        // Unknown offsets: writes vanish and reads return zero.
        offer(OP_WRITE, 8'hff,   32'hffff_ffff);
        offer(OP_READ,  8'h00,   32'h0);
        // Unmasked one-shot expiry, then a second expiry while still pending.
        offer(OP_WRITE, OFF_LVT, 32'h0000_005a);
        offer(OP_WRITE, OFF_ICR, 32'd1);
        offer(OP_TICK,  8'h00,   32'h0);
        offer(OP_WRITE, OFF_ICR, 32'd1);
        offer(OP_TICK,  8'h00,   32'h0);
        offer(OP_READ,  OFF_EOI, 32'h0);
        offer(OP_WRITE, OFF_EOI, 32'h0);
        offer(OP_NONE,  8'hff,   32'hffff_ffff);
        offer(OP_WRITE, OFF_ICR, 32'hffff_ffff);    // widest count
        offer(OP_READ,  OFF_ICR, 32'h0);
        offer(OP_WRITE, OFF_ICR, 32'h0);            // a zero count stops the timer
        offer(OP_TICK,  8'h00,   32'h0);
        // Divide change in the middle of a count: the prescaler already
        // stands past the new divisor, so the next tick is a divided edge.
        offer(OP_WRITE, OFF_DCR, 32'h0000_000a);
        offer(OP_WRITE, OFF_ICR, 32'd3);
        repeat (3) offer(OP_TICK, 8'h00, 32'h0);
        offer(OP_WRITE, OFF_DCR, 32'h0);
        offer(OP_TICK,  8'h00,   32'h0);
        offer(OP_READ,  OFF_CCR, 32'h0);
        wait_drained();

        // Random pass. Idling is chosen per timer program, so some stretches
        // run at full rate; the last part runs with no idling at all.
        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end)
        begin
            quiet           = (items_sent + QUIET_TAIL >= random_end);
            sender_idles    = !quiet && ($urandom_range(0, 2) != 0);
            receiver_stalls = !quiet && ($urandom_range(0, 2) != 0);
            if (!held_off && items_sent + 450 <= random_end)
            begin
                // Long receiver hold-off while ticks keep coming at full rate until the core stalls its input.
                held_off     = 1'b1;
                sender_idles = 1'b0;
                hold_request = 1'b1;
                repeat (16) offer(OP_TICK, 8'($urandom), $urandom);
            end
            else if (held_off && !paused && items_sent + 300 > random_end)
            begin
                // The sender pauses until every result is back.
                paused = 1'b1;
                wait_drained();
            end
            if ($urandom_range(0, 3) == 0)
                send_noise();
            else
                run_timer_program();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d transactions: %0d reads, %0d writes, %0d ticks.",
                 items_sent, reads_sent, writes_sent, ticks_sent);
        $display("Observed %0d timer interrupts in %0d cycles.", fires, cycle_count);
        if (failures == 0)
            $display("PASS local_apic_timer_core");
        else
            $display("FAIL local_apic_timer_core");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lapic_pkg.sv
rtl/core/lapic_timer_regs.sv
rtl/core/lapic_out_buf.sv
rtl/core/local_apic_timer_core.sv
tb/local_apic_timer_checker.sv
tb/local_apic_timer_core_test.sv
